@@ rtl/rgba_ovr_pkg.sv @@
// ----------------------------------------------------------------------------
// rgba_ovr_pkg
// Shared widths, lane codes and the beat format of the divider cell chain.
// ----------------------------------------------------------------------------
package rgba_ovr_pkg;

    localparam int unsigned CH_W  = 8;   // one RGBA channel
    localparam int unsigned DEN_W = 16;  // combined weight, up to 255*255
    localparam int unsigned NUM_W = 24;  // weighted channel sum, up to 255*D
    localparam int unsigned QUO_W = 8;   // quotient bits, one per cell
    localparam int unsigned LANES = 4;   // red, green, blue, alpha
    localparam int unsigned COLOR_LANES = 3;

    localparam logic [CH_W-1:0] FULL_SCALE = 8'd255;

    typedef logic [1:0] lane_idx_t;
    localparam lane_idx_t LANE_RED   = 2'd0;
    localparam lane_idx_t LANE_GREEN = 2'd1;
    localparam lane_idx_t LANE_BLUE  = 2'd2;
    localparam lane_idx_t LANE_ALPHA = 2'd3;

    typedef struct packed {
        logic [LANES-1:0][NUM_W-1:0] rem;
        logic [LANES-1:0][QUO_W-1:0] quo;
        logic [DEN_W-1:0]            den;
        logic                        zero;
    } div_beat_t;

endpackage

@@ rtl/rgba8_alpha_over_blend_core.sv @@
// ----------------------------------------------------------------------------
// rgba8_alpha_over_blend_core
// Porter-Duff "over" of one 8-bit RGBA source pixel onto a destination pixel.
//
//   channel   dir   handshake          payload
//   s_        in    s_valid/s_ready    s_src_{red,green,blue,alpha},
//                                      s_dst_{red,green,blue,alpha}
//   m_        out   m_valid/m_ready    m_out_{red,green,blue,alpha}
//
// One beat per cycle while m_ready stays high; three multiply/sum stages
// followed by a row of eight divider cells, one quotient bit per cell.
// Reset clears only the stage valid flags.
// Each stage holds while the one after it is full and stalled; empty stages
// keep filling, so s_ready drops only when every stage holds a beat.
// ----------------------------------------------------------------------------
module rgba8_alpha_over_blend_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rgba_ovr_pkg::CH_W-1:0] s_src_red,
    input  logic [rgba_ovr_pkg::CH_W-1:0] s_src_green,
    input  logic [rgba_ovr_pkg::CH_W-1:0] s_src_blue,
    input  logic [rgba_ovr_pkg::CH_W-1:0] s_src_alpha,
    input  logic [rgba_ovr_pkg::CH_W-1:0] s_dst_red,
    input  logic [rgba_ovr_pkg::CH_W-1:0] s_dst_green,
    input  logic [rgba_ovr_pkg::CH_W-1:0] s_dst_blue,
    input  logic [rgba_ovr_pkg::CH_W-1:0] s_dst_alpha,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rgba_ovr_pkg::CH_W-1:0] m_out_red,
    output logic [rgba_ovr_pkg::CH_W-1:0] m_out_green,
    output logic [rgba_ovr_pkg::CH_W-1:0] m_out_blue,
    output logic [rgba_ovr_pkg::CH_W-1:0] m_out_alpha
);

    localparam int unsigned CW = rgba_ovr_pkg::CH_W;
    localparam int unsigned QW = rgba_ovr_pkg::QUO_W;
    localparam int unsigned NW = rgba_ovr_pkg::NUM_W;
    localparam int unsigned CL = rgba_ovr_pkg::COLOR_LANES;

    logic [CL-1:0][CW-1:0] src_color;
    logic [CL-1:0][CW-1:0] dst_color;

    logic                    chain_valid [QW+1];
    logic                    chain_ready [QW+1];
    rgba_ovr_pkg::div_beat_t chain_beat  [QW+1];
    rgba_ovr_pkg::div_beat_t last_beat;

    assign src_color[rgba_ovr_pkg::LANE_RED]   = s_src_red;
    assign src_color[rgba_ovr_pkg::LANE_GREEN] = s_src_green;
    assign src_color[rgba_ovr_pkg::LANE_BLUE]  = s_src_blue;
    assign dst_color[rgba_ovr_pkg::LANE_RED]   = s_dst_red;
    assign dst_color[rgba_ovr_pkg::LANE_GREEN] = s_dst_green;
    assign dst_color[rgba_ovr_pkg::LANE_BLUE]  = s_dst_blue;

    rgba_ovr_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_src       (src_color),
        .in_src_alpha (s_src_alpha),
        .in_dst       (dst_color),
        .in_dst_alpha (s_dst_alpha),
        .out_valid    (chain_valid[0]),
        .out_ready    (chain_ready[0]),
        .out_beat     (chain_beat[0])
    );

    for (genvar k = 0; k < QW; k++) begin : g_cell
        rgba_ovr_cell #(
            .SHIFT (QW - 1 - k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[k]),
            .in_ready  (chain_ready[k]),
            .in_beat   (chain_beat[k]),
            .out_valid (chain_valid[k+1]),
            .out_ready (chain_ready[k+1]),
            .out_beat  (chain_beat[k+1])
        );
    end

    assign last_beat      = chain_beat[QW];
    assign m_valid        = chain_valid[QW];
    assign chain_ready[QW] = m_ready;

    // zero combined weight forces black
    assign m_out_red   = last_beat.zero ? '0 : last_beat.quo[rgba_ovr_pkg::LANE_RED];
    assign m_out_green = last_beat.zero ? '0 : last_beat.quo[rgba_ovr_pkg::LANE_GREEN];
    assign m_out_blue  = last_beat.zero ? '0 : last_beat.quo[rgba_ovr_pkg::LANE_BLUE];
    assign m_out_alpha = last_beat.quo[rgba_ovr_pkg::LANE_ALPHA];

`ifndef SYNTHESIS
    a_full_only_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled while output side can drain");

    a_empty_after_reset: assert property (@(posedge aclk)
        !$past(aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    a_color_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !last_beat.zero) |->
            (last_beat.rem[rgba_ovr_pkg::LANE_RED]   < NW'(last_beat.den)) &&
            (last_beat.rem[rgba_ovr_pkg::LANE_GREEN] < NW'(last_beat.den)) &&
            (last_beat.rem[rgba_ovr_pkg::LANE_BLUE]  < NW'(last_beat.den)))
        else $error("color division left remainder not below weight");

    a_alpha_rem_below_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (last_beat.rem[rgba_ovr_pkg::LANE_ALPHA] <
                     NW'(rgba_ovr_pkg::FULL_SCALE)))
        else $error("alpha division left remainder not below full scale");
`endif

endmodule

@@ rtl/rgba_ovr_front.sv @@
// ----------------------------------------------------------------------------
// rgba_ovr_front
// Three-stage weight and numerator pipeline; loads the first divider beat.
// ----------------------------------------------------------------------------
module rgba_ovr_front (
    input  logic                                                    aclk,
    input  logic                                                    aresetn,
    input  logic                                                    in_valid,
    output logic                                                    in_ready,
    input  logic [rgba_ovr_pkg::COLOR_LANES-1:0][rgba_ovr_pkg::CH_W-1:0] in_src,
    input  logic [rgba_ovr_pkg::CH_W-1:0]                           in_src_alpha,
    input  logic [rgba_ovr_pkg::COLOR_LANES-1:0][rgba_ovr_pkg::CH_W-1:0] in_dst,
    input  logic [rgba_ovr_pkg::CH_W-1:0]                           in_dst_alpha,
    output logic                                                    out_valid,
    input  logic                                                    out_ready,
    output rgba_ovr_pkg::div_beat_t                                 out_beat
);

    localparam int unsigned CW = rgba_ovr_pkg::CH_W;
    localparam int unsigned DW = rgba_ovr_pkg::DEN_W;
    localparam int unsigned NW = rgba_ovr_pkg::NUM_W;
    localparam int unsigned CL = rgba_ovr_pkg::COLOR_LANES;

    logic                     s1_valid_reg;
    logic [CL-1:0][CW-1:0]    s1_src_reg;
    logic [CL-1:0][CW-1:0]    s1_dst_reg;
    logic [CW-1:0]            s1_sa_reg;
    logic [DW-1:0]            s1_dw_reg;
    logic [DW-1:0]            s1_dw_next;

    logic                     s2_valid_reg;
    logic [CL-1:0][DW-1:0]    s2_ps_reg;
    logic [CL-1:0][NW-1:0]    s2_pd_reg;
    logic [DW-1:0]            s2_den_reg;
    logic [CL-1:0][DW-1:0]    s2_ps_next;
    logic [CL-1:0][NW-1:0]    s2_pd_next;
    logic [DW-1:0]            s2_den_next;

    logic                     s3_valid_reg;
    rgba_ovr_pkg::div_beat_t  s3_beat_reg;
    rgba_ovr_pkg::div_beat_t  s3_beat_next;

    logic s1_ready;
    logic s2_ready;
    logic s3_ready;

    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    assign out_valid = s3_valid_reg;
    assign out_beat  = s3_beat_reg;

    // destination weight Ad*(255-As)
    assign s1_dw_next = DW'(in_dst_alpha) * DW'(rgba_ovr_pkg::FULL_SCALE - in_src_alpha);

    always_comb begin
        for (int l = 0; l < CL; l++) begin
            s2_ps_next[l] = DW'(s1_src_reg[l]) * DW'(s1_sa_reg);
            s2_pd_next[l] = NW'(s1_dst_reg[l]) * NW'(s1_dw_reg);
        end
        s2_den_next = ({s1_sa_reg, 8'd0} - DW'(s1_sa_reg)) + s1_dw_reg;
    end

    always_comb begin
        s3_beat_next = '0;
        for (int l = 0; l < CL; l++) begin
            s3_beat_next.rem[l] = ({s2_ps_reg[l], 8'd0} - NW'(s2_ps_reg[l])) + s2_pd_reg[l];
        end
        s3_beat_next.rem[rgba_ovr_pkg::LANE_ALPHA] = NW'(s2_den_reg);
        s3_beat_next.den  = s2_den_reg;
        s3_beat_next.zero = (s2_den_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) s1_valid_reg <= in_valid;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
            if (s3_ready) s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && in_valid) begin
            s1_src_reg <= in_src;
            s1_dst_reg <= in_dst;
            s1_sa_reg  <= in_src_alpha;
            s1_dw_reg  <= s1_dw_next;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_ps_reg  <= s2_ps_next;
            s2_pd_reg  <= s2_pd_next;
            s2_den_reg <= s2_den_next;
        end
        if (s3_ready && s2_valid_reg) begin
            s3_beat_reg <= s3_beat_next;
        end
    end

endmodule

@@ rtl/rgba_ovr_cell.sv @@
// ----------------------------------------------------------------------------
// rgba_ovr_cell
// One restoring-division step for all four lanes; resolves quotient bit SHIFT.
// ----------------------------------------------------------------------------
module rgba_ovr_cell #(
    parameter int unsigned SHIFT = 0
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  rgba_ovr_pkg::div_beat_t in_beat,
    output logic                    out_valid,
    input  logic                    out_ready,
    output rgba_ovr_pkg::div_beat_t out_beat
);

    localparam int unsigned NW = rgba_ovr_pkg::NUM_W;
    localparam int unsigned DW = rgba_ovr_pkg::DEN_W;

    logic                    valid_reg;
    rgba_ovr_pkg::div_beat_t beat_reg;
    rgba_ovr_pkg::div_beat_t beat_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    always_comb begin
        logic [DW-1:0] divisor;
        logic [NW-1:0] trial;
        beat_next = in_beat;
        for (int l = 0; l < rgba_ovr_pkg::LANES; l++) begin
            divisor = (l == int'(rgba_ovr_pkg::LANE_ALPHA)) ?
                      DW'(rgba_ovr_pkg::FULL_SCALE) : in_beat.den;
            trial = NW'(divisor) << SHIFT;
            if (in_beat.rem[l] >= trial) begin
                beat_next.rem[l]        = in_beat.rem[l] - trial;
                beat_next.quo[l][SHIFT] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            beat_reg <= beat_next;
        end
    end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Checks the RGBA8 "over" blend core against an integer model of the blend.
// Directed corner pixels come first, then random pixel pairs under four
// idling mixes on the input and output channels, and then one long output
// hold-off that fills the pipe. Every output beat is compared lane by lane
// with the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CH_W        = rgba_ovr_pkg::CH_W;
    localparam int unsigned LANES       = rgba_ovr_pkg::LANES;
    localparam int unsigned COLOR_LANES = rgba_ovr_pkg::COLOR_LANES;

    localparam logic [CH_W-1:0] FULL_SCALE = rgba_ovr_pkg::FULL_SCALE;

    localparam rgba_ovr_pkg::lane_idx_t LANE_RED   = rgba_ovr_pkg::LANE_RED;
    localparam rgba_ovr_pkg::lane_idx_t LANE_GREEN = rgba_ovr_pkg::LANE_GREEN;
    localparam rgba_ovr_pkg::lane_idx_t LANE_BLUE  = rgba_ovr_pkg::LANE_BLUE;
    localparam rgba_ovr_pkg::lane_idx_t LANE_ALPHA = rgba_ovr_pkg::LANE_ALPHA;

    typedef logic [LANES-1:0][CH_W-1:0] rgba_t;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned HOLD_CYCLES = 300;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [CH_W-1:0] s_src_red = '0;
    logic [CH_W-1:0] s_src_green = '0;
    logic [CH_W-1:0] s_src_blue = '0;
    logic [CH_W-1:0] s_src_alpha = '0;
    logic [CH_W-1:0] s_dst_red = '0;
    logic [CH_W-1:0] s_dst_green = '0;
    logic [CH_W-1:0] s_dst_blue = '0;
    logic [CH_W-1:0] s_dst_alpha = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [CH_W-1:0] m_out_red;
    logic [CH_W-1:0] m_out_green;
    logic [CH_W-1:0] m_out_blue;
    logic [CH_W-1:0] m_out_alpha;

    rgba_t expected_pixels[$];
    int unsigned mismatches = 0;
    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;

    rgba8_alpha_over_blend_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_src_red   (s_src_red),
        .s_src_green (s_src_green),
        .s_src_blue  (s_src_blue),
        .s_src_alpha (s_src_alpha),
        .s_dst_red   (s_dst_red),
        .s_dst_green (s_dst_green),
        .s_dst_blue  (s_dst_blue),
        .s_dst_alpha (s_dst_alpha),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_red   (m_out_red),
        .m_out_green (m_out_green),
        .m_out_blue  (m_out_blue),
        .m_out_alpha (m_out_alpha)
    );

    always #5 aclk = ~aclk;

    function automatic rgba_t make_rgba(input int unsigned r, input int unsigned g,
                                        input int unsigned b, input int unsigned a);
        rgba_t px;
        px[LANE_RED]   = r[CH_W-1:0];
        px[LANE_GREEN] = g[CH_W-1:0];
        px[LANE_BLUE]  = b[CH_W-1:0];
        px[LANE_ALPHA] = a[CH_W-1:0];
        return px;
    endfunction

    // Source over destination, non-premultiplied, exact integer form.
    function automatic rgba_t blend_over(input rgba_t src, input rgba_t dst);
        rgba_t px;
        int unsigned scale;
        int unsigned sa;
        int unsigned dst_weight;
        int unsigned total;
        scale = 32'(FULL_SCALE);
        sa = 32'(src[LANE_ALPHA]);
        dst_weight = 32'(dst[LANE_ALPHA]) * (scale - sa);
        total = scale * sa + dst_weight;
        for (int l = 0; l < COLOR_LANES; l++) begin
            if (total == 0) begin
                px[l] = '0;
            end else begin
                px[l] = CH_W'((scale * 32'(src[l]) * sa + 32'(dst[l]) * dst_weight) / total);
            end
        end
        px[LANE_ALPHA] = CH_W'(total / scale);
        return px;
    endfunction

    task automatic send_pixel(input rgba_t src, input rgba_t dst);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_src_red   <= src[LANE_RED];
        s_src_green <= src[LANE_GREEN];
        s_src_blue  <= src[LANE_BLUE];
        s_src_alpha <= src[LANE_ALPHA];
        s_dst_red   <= dst[LANE_RED];
        s_dst_green <= dst[LANE_GREEN];
        s_dst_blue  <= dst[LANE_BLUE];
        s_dst_alpha <= dst[LANE_ALPHA];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_pixels.push_back(blend_over(src, dst));
        @(negedge aclk);
    endtask

    // Channel values lean toward the ends of the range.
    function automatic int unsigned pick_level();
        int unsigned ends[4] = '{0, 1, 254, 255};
        if ($urandom_range(3) == 0) return ends[$urandom_range(3)];
        return $urandom_range(255);
    endfunction

    task automatic run_random(input int unsigned count);
        rgba_t src;
        rgba_t dst;
        repeat (count) begin
            src = make_rgba(pick_level(), pick_level(), pick_level(), pick_level());
            dst = make_rgba(pick_level(), pick_level(), pick_level(), pick_level());
            send_pixel(src, dst);
        end
    endtask

    task automatic test_directed_corners();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        send_pixel(make_rgba(0, 0, 0, 0), make_rgba(0, 0, 0, 0));
        // both alphas zero: colors forced to zero
        send_pixel(make_rgba(255, 255, 255, 0), make_rgba(255, 255, 255, 0));
        send_pixel(make_rgba(170, 85, 255, 0), make_rgba(85, 170, 1, 0));
        send_pixel(make_rgba(255, 255, 255, 255), make_rgba(255, 255, 255, 255));
        send_pixel(make_rgba(10, 200, 77, 255), make_rgba(255, 0, 128, 255));
        send_pixel(make_rgba(10, 200, 77, 0), make_rgba(255, 0, 128, 255));
        send_pixel(make_rgba(255, 0, 255, 1), make_rgba(0, 255, 0, 0));
        send_pixel(make_rgba(255, 0, 255, 0), make_rgba(0, 255, 0, 1));
        send_pixel(make_rgba(255, 255, 255, 1), make_rgba(0, 0, 0, 1));
        send_pixel(make_rgba(0, 0, 0, 254), make_rgba(255, 255, 255, 255));
        send_pixel(make_rgba(255, 255, 255, 254), make_rgba(255, 255, 255, 255));
        send_pixel(make_rgba(255, 255, 255, 128), make_rgba(255, 255, 255, 128));
        send_pixel(make_rgba(170, 170, 170, 170), make_rgba(85, 85, 85, 85));
        send_pixel(make_rgba(85, 85, 85, 85), make_rgba(170, 170, 170, 170));
        send_pixel(make_rgba(1, 2, 4, 8), make_rgba(16, 32, 64, 128));
        send_pixel(make_rgba(254, 253, 251, 247), make_rgba(239, 223, 191, 127));
        send_pixel(make_rgba(255, 255, 255, 1), make_rgba(255, 255, 255, 254));
        send_pixel(make_rgba(0, 128, 255, 127), make_rgba(255, 128, 0, 255));
        send_pixel(make_rgba(200, 100, 50, 255), make_rgba(0, 0, 0, 0));
        send_pixel(make_rgba(0, 0, 0, 0), make_rgba(200, 100, 50, 3));
    endtask

    task automatic test_random_no_idle();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        run_random(340);
    endtask

    task automatic test_random_sender_idle();
        src_idle_pct = 61;
        sink_stall_pct = 0;
        run_random(340);
    endtask

    task automatic test_random_sink_stall();
        src_idle_pct = 0;
        sink_stall_pct = 61;
        run_random(340);
    endtask

    task automatic test_random_both_idle();
        src_idle_pct = 29;
        sink_stall_pct = 29;
        run_random(340);
    endtask

    // Output held off while beats keep coming; the pipe fills and s_ready drops.
    task automatic test_sink_holdoff();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_left = HOLD_CYCLES;
        run_random(60);
    endtask

    always @(posedge aclk) begin
        if (hold_left != 0) hold_left <= hold_left - 1;
    end

    always @(negedge aclk) begin
        m_ready <= (hold_left == 0) && ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        rgba_t got;
        rgba_t want;
        string lane_name[LANES];
        lane_name[LANE_RED]   = "out_red";
        lane_name[LANE_GREEN] = "out_green";
        lane_name[LANE_BLUE]  = "out_blue";
        lane_name[LANE_ALPHA] = "out_alpha";
        if (aresetn && m_valid && m_ready) begin
            got = make_rgba(32'(m_out_red), 32'(m_out_green),
                            32'(m_out_blue), 32'(m_out_alpha));
            if (expected_pixels.size() == 0) begin
                $error("unexpected output beat %h", got);
                mismatches++;
            end else begin
                want = expected_pixels.pop_front();
                for (int l = 0; l < LANES; l++) begin
                    if (got[l] !== want[l]) begin
                        $error("%s expected %0d actual %0d", lane_name[l], want[l], got[l]);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_corners();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_sink_stall();
        test_random_both_idle();
        test_sink_holdoff();

        s_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
